>>> rtl/afm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_pkg
// Shared types, constants and tables of the asymmetric FSK modulator.
// ----------------------------------------------------------------------------
package afm_pkg;

    // Default sizes of the datapath.
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int PHASE_BITS_DEF    = 32;
    localparam int OUT_BITS_DEF      = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Fixed sizes.
    localparam int GAIN_BITS     = 32;
    localparam int CFG_ADDR_BITS = 1;
    localparam int GUARD_BITS    = 8;
    localparam int ATAN_ENTRIES  = 24;
    localparam int TURN_BITS     = 32;
    localparam int STEP_Q_DEPTH  = 4;

    // Reciprocal of the CORDIC gain in Q32.
    localparam longint unsigned INV_GAIN_Q32 = 64'd2608131496;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_GAIN_NONNEG = 1'b0,
        REG_GAIN_NEG    = 1'b1
    } t_reg_idx;

    // One configuration write as seen by the front end.
    typedef struct packed {
        logic                 we;
        t_reg_idx             idx;
        logic [GAIN_BITS-1:0] data;
    } t_cfg_wr;

    // Arctangent of 2^-i in Q32 turns.
    function automatic logic [TURN_BITS-1:0] atan_turn(input int i);
        logic [TURN_BITS-1:0] v;
        case (i)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Start vector of the rotation: full-scale amplitude with guard bits,
    // divided by the CORDIC gain.
    function automatic longint unsigned cordic_x0(input int out_bits);
        longint unsigned amp;
        amp = (64'd1 << (out_bits - 1)) - 64'd1;
        return ((amp << GUARD_BITS) * INV_GAIN_Q32) >> 32;
    endfunction

endpackage

>>> rtl/afm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_front
// Holds the gain registers, picks the gain by the sign of each sample and
// registers the scaled phase step.
// ----------------------------------------------------------------------------
module afm_front #(
    parameter int SAMPLE_BITS = afm_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = afm_pkg::PHASE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  afm_pkg::t_cfg_wr       i_cfg,
    output logic                   o_phase_clr,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [PHASE_BITS-1:0]  o_step
);

    localparam int GW     = afm_pkg::GAIN_BITS;
    localparam int PROD_W = SAMPLE_BITS + GW;
    localparam int SHIFT  = PHASE_BITS - (SAMPLE_BITS - 1) - 16;
    localparam int SH_W   = PROD_W + ((SHIFT > 0) ? SHIFT : 0);

    logic [GW-1:0]               r_gain_nonneg;
    logic [GW-1:0]               r_gain_neg;
    logic                        r_vld;
    logic                        n_vld;
    logic [PHASE_BITS-1:0]       r_step;
    logic signed [GW-1:0]        w_gain;
    logic signed [PROD_W-1:0]    w_prod;
    logic [PHASE_BITS-1:0]       w_step;
    logic                        w_accept;

    // Configuration decode; every legal index clears the phase.
    always_comb begin
        o_phase_clr = 1'b0;
        case (i_cfg.idx)
            afm_pkg::REG_GAIN_NONNEG: o_phase_clr = i_cfg.we;
            afm_pkg::REG_GAIN_NEG:    o_phase_clr = i_cfg.we;
            default:                  o_phase_clr = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_nonneg <= '0;
            r_gain_neg    <= '0;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                afm_pkg::REG_GAIN_NONNEG: r_gain_nonneg <= i_cfg.data;
                afm_pkg::REG_GAIN_NEG:    r_gain_neg    <= i_cfg.data;
                default:                  ;
            endcase
        end
    end

    // Negative samples use their own gain.
    assign w_gain = i_sample[SAMPLE_BITS-1] ? $signed(r_gain_neg) : $signed(r_gain_nonneg);
    assign w_prod = PROD_W'($signed(i_sample)) * PROD_W'(w_gain);

    // Scale the product to phase units; a right shift floors.
    generate
        if (SHIFT >= 0) begin : g_left
            logic signed [SH_W-1:0] w_ext;
            assign w_ext  = SH_W'(w_prod);
            assign w_step = PHASE_BITS'(w_ext <<< SHIFT);
        end else begin : g_right
            logic signed [PROD_W-1:0] w_shr;
            assign w_shr  = w_prod >>> (-SHIFT);
            assign w_step = w_shr[PHASE_BITS-1:0];
        end
    endgenerate

    assign o_ready  = !r_vld || i_ready;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_vld = r_vld;
        if (w_accept) begin
            n_vld = 1'b1;
        end else if (i_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_step <= w_step;
        end
    end

    assign o_valid = r_vld;
    assign o_step  = r_step;

endmodule

>>> rtl/afm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_fifo
// Short first-in first-out queue of phase steps between front and back end.
// ----------------------------------------------------------------------------
module afm_fifo #(
    parameter int WIDTH = afm_pkg::PHASE_BITS_DEF,
    parameter int DEPTH = afm_pkg::STEP_Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    // DEPTH is a power of two so the pointers wrap on their own.
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/afm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_back
// Phase accumulator followed by a pipelined CORDIC sin/cos generator and a
// result register.
// ----------------------------------------------------------------------------
module afm_back #(
    parameter int PHASE_BITS    = afm_pkg::PHASE_BITS_DEF,
    parameter int OUT_BITS      = afm_pkg::OUT_BITS_DEF,
    parameter int CORDIC_STAGES = afm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_phase_clr,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PHASE_BITS-1:0] i_step,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_BITS-1:0]   o_i,
    output logic [OUT_BITS-1:0]   o_q
);

    localparam int TW = afm_pkg::TURN_BITS;
    localparam int G  = afm_pkg::GUARD_BITS;
    localparam int NST = (CORDIC_STAGES > afm_pkg::ATAN_ENTRIES) ?
                         afm_pkg::ATAN_ENTRIES : CORDIC_STAGES;
    localparam int XW = OUT_BITS + G + 2;
    localparam int ZW = TW + 2;
    localparam logic signed [XW-1:0] X0   = XW'(afm_pkg::cordic_x0(OUT_BITS));
    localparam logic signed [XW:0]   HALF = (XW+1)'(1) <<< (G - 1);
    localparam logic signed [XW:0]   OHI  = ((XW+1)'(1) <<< (OUT_BITS - 1)) - (XW+1)'(1);
    localparam logic signed [XW:0]   OLO  = ~OHI;

    logic                   w_en;
    logic                   w_pop;
    logic [PHASE_BITS-1:0]  r_phase;
    logic [PHASE_BITS-1:0]  w_phase_nxt;
    logic [TW-1:0]          w_turn;
    logic                   w_flip;

    logic                   r_vld  [NST+1];
    logic                   r_flip [NST+1];
    logic signed [XW-1:0]   r_x    [NST+1];
    logic signed [XW-1:0]   r_y    [NST+1];
    logic signed [ZW-1:0]   r_z    [NST+1];

    logic                   r_out_vld;
    logic [OUT_BITS-1:0]    r_out_i;
    logic [OUT_BITS-1:0]    r_out_q;
    logic signed [XW:0]     w_xs;
    logic signed [XW:0]     w_ys;
    logic signed [XW:0]     w_xn;
    logic signed [XW:0]     w_yn;
    logic signed [XW:0]     w_xc;
    logic signed [XW:0]     w_yc;

    // The whole pipeline advances unless a result waits at the output.
    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;
    assign w_pop   = i_valid && w_en;

    assign w_phase_nxt = r_phase + i_step;

    generate
        if (PHASE_BITS >= TW) begin : g_trunc
            assign w_turn = w_phase_nxt[PHASE_BITS-1 -: TW];
        end else begin : g_pad
            assign w_turn = {w_phase_nxt, {(TW - PHASE_BITS){1'b0}}};
        end
    endgenerate

    // Second and third quadrant: rotate by a half turn, negate at the end.
    assign w_flip = w_turn[TW-1] ^ w_turn[TW-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_phase_clr) begin
            r_phase <= '0;
        end else if (w_pop) begin
            r_phase <= w_phase_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flip[0] <= w_flip;
            r_x[0]    <= X0;
            r_y[0]    <= '0;
            r_z[0]    <= ZW'($signed({w_turn[TW-1] ^ w_flip, w_turn[TW-2:0]}));
        end
    end

    generate
        for (genvar i = 0; i < NST; i++) begin : g_stage
            localparam logic signed [ZW-1:0] ATAN = ZW'(afm_pkg::atan_turn(i));
            logic signed [XW-1:0] w_xsh;
            logic signed [XW-1:0] w_ysh;

            assign w_xsh = r_x[i] >>> i;
            assign w_ysh = r_y[i] >>> i;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[i+1] <= 1'b0;
                end else if (w_en) begin
                    r_vld[i+1] <= r_vld[i];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_flip[i+1] <= r_flip[i];
                    if (!r_z[i][ZW-1]) begin
                        r_x[i+1] <= r_x[i] - w_ysh;
                        r_y[i+1] <= r_y[i] + w_xsh;
                        r_z[i+1] <= r_z[i] - ATAN;
                    end else begin
                        r_x[i+1] <= r_x[i] + w_ysh;
                        r_y[i+1] <= r_y[i] - w_xsh;
                        r_z[i+1] <= r_z[i] + ATAN;
                    end
                end
            end
        end
    endgenerate

    // Drop the guard bits rounding half up, undo the flip and saturate.
    assign w_xs = ((XW+1)'(r_x[NST]) + HALF) >>> G;
    assign w_ys = ((XW+1)'(r_y[NST]) + HALF) >>> G;
    assign w_xn = r_flip[NST] ? -w_xs : w_xs;
    assign w_yn = r_flip[NST] ? -w_ys : w_ys;

    always_comb begin
        w_xc = w_xn;
        if (w_xn > OHI) begin
            w_xc = OHI;
        end else if (w_xn < OLO) begin
            w_xc = OLO;
        end
        w_yc = w_yn;
        if (w_yn > OHI) begin
            w_yc = OHI;
        end else if (w_yn < OLO) begin
            w_yc = OLO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_i <= w_xc[OUT_BITS-1:0];
            r_out_q <= w_yc[OUT_BITS-1:0];
        end
    end

    assign o_valid = r_out_vld;
    assign o_i     = r_out_i;
    assign o_q     = r_out_q;

endmodule

>>> rtl/asymmetric_fsk_modulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asymmetric_fsk_modulator
// FM/FSK modulator with separate gains for non-negative and negative samples.
// ----------------------------------------------------------------------------
// Each signed sample taken on the input stream is multiplied by gain_nonneg
// (sample zero or above) or by gain_neg (sample below zero), both Q16 turns
// per full-scale sample, and the scaled product is added to a phase
// accumulator that wraps modulo one turn. The new phase drives a pipelined
// CORDIC with CORDIC_STAGES rotation stages, which returns the cosine (I)
// and the sine (Q) of that phase as signed Q15 values, rounded and
// saturated. One result item leaves for every input item. The block takes
// one item per clock for as long as the output is taken. An item passes
// through CORDIC_STAGES + 4 registers, the first of them loaded at the edge
// that accepts it: one for the gain multiply, one in the step queue, one
// for the accumulator, one per CORDIC stage and one for the result
// register. A four-entry queue of phase steps lets the input side keep
// accepting while the output is stalled, until the queue and the
// front-end step register are full. The user must write the gains
// through the configuration port only while the block is idle; the block
// itself does not enforce this. Any write to either gain also clears the
// phase to zero. Configuration writes take effect at the clock edge at
// which i_cfg_we is high.
// ----------------------------------------------------------------------------
module asymmetric_fsk_modulator #(
    parameter int SAMPLE_BITS   = afm_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS    = afm_pkg::PHASE_BITS_DEF,
    parameter int OUT_BITS      = afm_pkg::OUT_BITS_DEF,
    parameter int CORDIC_STAGES = afm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [afm_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [afm_pkg::GAIN_BITS-1:0]         i_cfg_wdata,
    // Input stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: sample, then zero padding up to a whole byte.
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: i_out, then q_out, then zero padding up to a whole byte.
    output logic [((2 * OUT_BITS + 7) / 8) * 8-1:0] m_axis_tdata
);

    localparam int OUT_TW = ((2 * OUT_BITS + 7) / 8) * 8;

    afm_pkg::t_cfg_wr        w_cfg;
    logic                    w_phase_clr;
    logic                    w_f_valid;
    logic                    w_f_ready;
    logic [PHASE_BITS-1:0]   w_f_step;
    logic                    w_q_valid;
    logic                    w_q_ready;
    logic [PHASE_BITS-1:0]   w_q_step;
    logic [OUT_BITS-1:0]     w_i;
    logic [OUT_BITS-1:0]     w_q;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = afm_pkg::t_reg_idx'(i_cfg_addr);
    assign w_cfg.data = i_cfg_wdata;

    // Front end: gain registers, gain selection and the step multiply.
    afm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .o_phase_clr (w_phase_clr),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_valid     (w_f_valid),
        .i_ready     (w_f_ready),
        .o_step      (w_f_step)
    );

    // Queue of phase steps between the two halves.
    afm_fifo #(
        .WIDTH (PHASE_BITS),
        .DEPTH (afm_pkg::STEP_Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_step),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_step)
    );

    // Back end: phase accumulator, CORDIC pipeline and result register.
    afm_back #(
        .PHASE_BITS    (PHASE_BITS),
        .OUT_BITS      (OUT_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_phase_clr (w_phase_clr),
        .i_valid     (w_q_valid),
        .o_ready     (w_q_ready),
        .i_step      (w_q_step),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_i         (w_i),
        .o_q         (w_q)
    );

    assign m_axis_tdata = OUT_TW'({w_q, w_i});

endmodule

>>> bench/tb_asymmetric_fsk_modulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_asymmetric_fsk_modulator
// Self-checking bench for the asymmetric FSK modulator.
// ----------------------------------------------------------------------------
// The bench streams signed samples into the modulator and checks every I/Q
// result against its own bit-exact model of the phase accumulator and the
// CORDIC sin/cos generator. Both stream sides idle at random. The output side
// also holds off once for a long stretch so that the input backs up. Gains
// are reprogrammed between phases while the block is drained, covering the
// extreme, zero and random settings.
// ----------------------------------------------------------------------------
module tb_asymmetric_fsk_modulator;

    // Pipeline depth of the block and bench limits.
    localparam int  PIPE_LATENCY  = afm_pkg::CORDIC_STAGES_DEF + 4;
    localparam int  CYCLE_LIMIT   = 1000000;
    localparam int  HOLD_CYCLES   = 300;
    localparam int  PHASE_ITEMS   = 200;
    localparam int  NUM_PHASES    = 8;

    // Constants of the sin/cos generator model.
    localparam int     OUT_W          = afm_pkg::OUT_BITS_DEF;
    localparam int     CORDIC_GUARD   = 8;
    localparam longint OUT_FULL       = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint OUT_MIN        = -OUT_FULL - 1;
    localparam longint CORDIC_INV_GAIN = 64'sd2608131496;

    // One expected result item.
    typedef struct packed {
        logic signed [OUT_W-1:0] q_val;
        logic signed [OUT_W-1:0] i_val;
    } t_iq_pair;

    // ------------------------------------------------------------------------
    // Model of the modulator and store of the I/Q pairs still to come.
    // ------------------------------------------------------------------------
    class nco_iq_scoreboard;
        logic signed [afm_pkg::GAIN_BITS-1:0] gain_nonneg = '0;
        logic signed [afm_pkg::GAIN_BITS-1:0] gain_neg    = '0;
        logic [31:0]                          phase_acc   = '0;
        t_iq_pair                             pending_iq[$];
        int                                   errors      = 0;

        function longint atan_q32(int i);
            case (i)
                0:       return 536870912;
                1:       return 316933406;
                2:       return 167458907;
                3:       return 85004756;
                4:       return 42667331;
                5:       return 21354465;
                6:       return 10679838;
                7:       return 5340245;
                8:       return 2670163;
                9:       return 1335087;
                10:      return 667544;
                11:      return 333772;
                12:      return 166886;
                13:      return 83443;
                14:      return 41722;
                15:      return 20861;
                16:      return 10430;
                17:      return 5215;
                18:      return 2608;
                19:      return 1304;
                20:      return 652;
                21:      return 326;
                22:      return 163;
                23:      return 81;
                default: return 0;
            endcase
        endfunction

        // Any gain write restarts the oscillator at phase zero.
        function void write_gain(afm_pkg::t_reg_idx idx,
                                 logic [afm_pkg::GAIN_BITS-1:0] value);
            case (idx)
                afm_pkg::REG_GAIN_NONNEG: gain_nonneg = value;
                afm_pkg::REG_GAIN_NEG:    gain_neg    = value;
                default: ;
            endcase
            phase_acc = '0;
        endfunction

        // Cosine and sine of a phase given in 32-bit turns.
        function t_iq_pair sincos_of(logic [31:0] ph);
            logic [31:0] a;
            bit          flip;
            longint      x, y, z, nx, ny;
            t_iq_pair    r;
            a = ph;
            // Second and third quadrants are folded by a half turn.
            flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
            if (flip) begin
                a = a - 32'h8000_0000;
            end
            z = longint'($signed(a));
            x = ((OUT_FULL <<< CORDIC_GUARD) * CORDIC_INV_GAIN) >>> 32;
            y = 0;
            for (int i = 0; i < afm_pkg::CORDIC_STAGES_DEF; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - atan_q32(i);
                end else begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + atan_q32(i);
                end
                x = nx;
                y = ny;
            end
            x = (x + (64'sd1 <<< (CORDIC_GUARD - 1))) >>> CORDIC_GUARD;
            y = (y + (64'sd1 <<< (CORDIC_GUARD - 1))) >>> CORDIC_GUARD;
            if (flip) begin
                x = -x;
                y = -y;
            end
            if (x > OUT_FULL) x = OUT_FULL;
            if (x < OUT_MIN)  x = OUT_MIN;
            if (y > OUT_FULL) y = OUT_FULL;
            if (y < OUT_MIN)  y = OUT_MIN;
            r.i_val = x[OUT_W-1:0];
            r.q_val = y[OUT_W-1:0];
            return r;
        endfunction

        // Step is sample * gain * 2, wrapped to one turn.
        function void take_sample(logic signed [15:0] smp);
            longint prod;
            prod = longint'(smp) * longint'(smp >= 0 ? gain_nonneg : gain_neg);
            phase_acc = phase_acc + {prod[30:0], 1'b0};
            pending_iq.push_back(sincos_of(phase_acc));
        endfunction

        function void check_iq(logic [2*OUT_W-1:0] word);
            t_iq_pair got, want;
            got = word;
            if (pending_iq.size() == 0) begin
                $error("unexpected result item: i_out %0d, q_out %0d",
                       got.i_val, got.q_val);
                errors++;
                return;
            end
            want = pending_iq.pop_front();
            if (got.i_val !== want.i_val) begin
                $error("i_out mismatch: expected %0d, actual %0d", want.i_val, got.i_val);
                errors++;
            end
            if (got.q_val !== want.q_val) begin
                $error("q_out mismatch: expected %0d, actual %0d", want.q_val, got.q_val);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_iq.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block inputs start at known values.
    // ------------------------------------------------------------------------
    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_cfg_we      = 1'b0;
    logic [afm_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr    = '0;
    logic [afm_pkg::GAIN_BITS-1:0]      i_cfg_wdata   = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [15:0]                        s_axis_tdata  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [2*OUT_W-1:0]                 m_axis_tdata;

    nco_iq_scoreboard sb = new;
    int  cycle_count  = 0;
    bit  no_idle      = 1'b0;   // both sides run flat out
    bit  hold_request = 1'b0;   // asks the receiver for one long hold-off
    bit  hold_active  = 1'b0;   // receiver is in that hold-off

    asymmetric_fsk_modulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // i_out, q_out
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL asymmetric_fsk_modulator");
            $finish;
        end
    end

    // Everything the block takes or gives at an edge is seen here, with the
    // values from just before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.write_gain(afm_pkg::t_reg_idx'(i_cfg_addr), i_cfg_wdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_iq(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.take_sample(s_axis_tdata);
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(1, 3);
    endfunction

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin : receiver
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                m_axis_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge i_clk);
                end
                hold_active = 1'b0;
            end else if (no_idle || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                n = gap_len();
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Offers one sample after an optional gap and waits for it to be taken.
    task automatic send_sample(input logic [15:0] smp);
        int g;
        g = 0;
        if (!no_idle && !hold_active && $urandom_range(0, 3) == 0) begin
            g = gap_len();
        end
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stops the input and waits until every pending I/Q pair has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
    endtask

    // One register write; the write enable goes low again after it so writes stay apart.
    task automatic program_gain(input afm_pkg::t_reg_idx idx,
                                input logic [afm_pkg::GAIN_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_gains(input logic [afm_pkg::GAIN_BITS-1:0] g_pos,
                                 input logic [afm_pkg::GAIN_BITS-1:0] g_negv);
        program_gain(afm_pkg::REG_GAIN_NONNEG, g_pos);
        program_gain(afm_pkg::REG_GAIN_NEG, g_negv);
    endtask

    // Extremes, tiny values and fully random words.
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 255));
            3:       return -16'($urandom_range(1, 256));
            default: return 16'($urandom());
        endcase
    endfunction

    // Either a full random word or a moderate FM-style gain of either sign.
    function automatic logic [afm_pkg::GAIN_BITS-1:0] rand_gain();
        logic [afm_pkg::GAIN_BITS-1:0] g;
        if ($urandom_range(0, 1) == 0) begin
            g = $urandom();
        end else begin
            g = $urandom_range(0, 1 << 18);
            if ($urandom_range(0, 1) == 0) begin
                g = -g;
            end
        end
        return g;
    endfunction

    initial begin : stimulus
        logic [afm_pkg::GAIN_BITS-1:0] g_pos, g_negv;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the reset gains the phase stays at zero.
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain();

        // A quarter turn per step walks through all four quadrant edges.
        program_gains(32'd32768, 32'd32768);
        repeat (4) send_sample(16'd16384);
        send_sample(-16'sd16384);
        send_sample(-16'sd16384);
        send_sample(16'd0);
        drain();

        // Opposite gains with the sample extremes and the smallest steps.
        program_gains(32'd65536, -32'sd65536);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'd1);
        send_sample(16'hFFFF);
        send_sample(16'd0);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        drain();

        // Gain extremes drive the phase through many wraps.
        program_gains(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'hFFFF);
        send_sample(16'd1);
        drain();

        program_gains(32'd0, 32'd0);
        send_sample(16'd12345);
        send_sample(-16'sd12345);
        drain();

        // Random phases, each starting from a fresh gain setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin g_pos = 32'h7FFF_FFFF; g_negv = 32'h8000_0000; end
                1: begin g_pos = 32'h8000_0000; g_negv = 32'h7FFF_FFFF; end
                2: begin g_pos = 32'd0;         g_negv = rand_gain();   end
                default: begin g_pos = rand_gain(); g_negv = rand_gain(); end
            endcase
            program_gains(g_pos, g_negv);

            // Output stalled for a long stretch while input keeps coming.
            if (p == 3) begin
                hold_request = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                no_idle = (p == 4) && (k < PHASE_ITEMS / 2);
                // Mid-phase pause, then a single gain rewrite clears the phase.
                if (p == 5 && k == PHASE_ITEMS / 2) begin
                    drain();
                    program_gain(afm_pkg::REG_GAIN_NEG, g_negv);
                end
                send_sample(rand_sample());
            end
            no_idle = 1'b0;
            drain();
        end

        if (sb.pending_count() != 0) begin
            $error("%0d expected result items never arrived", sb.pending_count());
        end
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("PASS asymmetric_fsk_modulator");
        end else begin
            $display("FAIL asymmetric_fsk_modulator");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/afm_pkg.sv
rtl/afm_front.sv
rtl/afm_fifo.sv
rtl/afm_back.sv
rtl/asymmetric_fsk_modulator.sv
bench/tb_asymmetric_fsk_modulator.sv
